>>> src/nested_bracket_mask_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the nested bracket mask core
// Clocked checks on clk_i, disabled while rst_ni is low; empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef NESTED_BRACKET_MASK_CORE_ASSERT_SVH
`define NESTED_BRACKET_MASK_CORE_ASSERT_SVH

`ifndef SYNTH
// Property checked on every rising edge outside reset
`define NBM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Implication checked on every rising edge outside reset
`define NBM_ASSERT_IMP(label, ante, cons, msg) \
  `NBM_ASSERT(label, (ante) |-> (cons), msg)
`else
`define NBM_ASSERT(label, prop, msg)
`define NBM_ASSERT_IMP(label, ante, cons, msg)
`endif

`endif

>>> src/nbm_pkg.sv
// ----------------------------------------------------------------------------
// nbm_pkg
// Shared types and constants of the nested bracket mask core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nbm_pkg;

  // Default stack depth and queue depth
  localparam int unsigned NbmMaxDepth   = 16;
  localparam int unsigned NbmQueueDepth = 2;

  // Pairs and configuration register map
  localparam int unsigned NbmPairs   = 4;
  localparam int unsigned NbmCfgIdxW = 3;
  localparam int unsigned NbmCharW   = 8;

  typedef enum logic [NbmCfgIdxW-1:0] {
    RegOpen0  = 3'd0,
    RegOpen1  = 3'd1,
    RegOpen2  = 3'd2,
    RegOpen3  = 3'd3,
    RegClose0 = 3'd4,
    RegClose1 = 3'd5,
    RegClose2 = 3'd6,
    RegClose3 = 3'd7
  } cfg_reg_e;

  // Mask classes
  typedef enum logic [1:0] {
    ClsOutside = 2'd0,
    ClsOpen    = 2'd1,
    ClsInside  = 2'd2,
    ClsClose   = 2'd3
  } cls_e;

  // Classified character handed from front to back
  typedef struct packed {
    logic [NbmCharW-1:0] ch;
    logic                last;
    logic                hit;
    logic [NbmCharW-1:0] closer;
  } cmd_t;

  // One result
  typedef struct packed {
    cls_e       cls;
    logic [4:0] depth;
    logic       ovf;
  } res_t;

endpackage

`default_nettype wire

>>> src/nbm_fifo.sv
// ----------------------------------------------------------------------------
// nbm_fifo
// Small synchronous queue with full/empty flags; push and pop may coincide.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nbm_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = nbm_pkg::NbmQueueDepth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [Width-1:0] rdata_o,
  output logic                  empty_o
);

  // Depth is a power of two, at least 2
  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

>>> src/nbm_front.sv
// ----------------------------------------------------------------------------
// nbm_front
// Holds the delimiter registers and classifies each character against the
// four openers; the first matching pair selects the closer to push.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nbm_front (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [nbm_pkg::NbmCfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [nbm_pkg::NbmCharW-1:0]         cfg_wdata_i,
  input  wire logic [nbm_pkg::NbmCharW-1:0]         ch_i,
  input  wire logic                                 last_i,
  output nbm_pkg::cmd_t                             cmd_o
);

  logic [nbm_pkg::NbmCharW-1:0] open_q  [nbm_pkg::NbmPairs];
  logic [nbm_pkg::NbmCharW-1:0] close_q [nbm_pkg::NbmPairs];

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < nbm_pkg::NbmPairs; i++) begin
        open_q[i]  <= '0;
        close_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (nbm_pkg::cfg_reg_e'(cfg_idx_i))
        nbm_pkg::RegOpen0:  open_q[0]  <= cfg_wdata_i;
        nbm_pkg::RegOpen1:  open_q[1]  <= cfg_wdata_i;
        nbm_pkg::RegOpen2:  open_q[2]  <= cfg_wdata_i;
        nbm_pkg::RegOpen3:  open_q[3]  <= cfg_wdata_i;
        nbm_pkg::RegClose0: close_q[0] <= cfg_wdata_i;
        nbm_pkg::RegClose1: close_q[1] <= cfg_wdata_i;
        nbm_pkg::RegClose2: close_q[2] <= cfg_wdata_i;
        nbm_pkg::RegClose3: close_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Opener match, lowest pair wins; a zero opener is disabled
  always_comb begin
    cmd_o.ch     = ch_i;
    cmd_o.last   = last_i;
    cmd_o.hit    = 1'b0;
    cmd_o.closer = '0;
    for (int i = nbm_pkg::NbmPairs - 1; i >= 0; i--) begin
      if (open_q[i] != '0 && open_q[i] == ch_i) begin
        cmd_o.hit    = 1'b1;
        cmd_o.closer = close_q[i];
      end
    end
  end

endmodule

`default_nettype wire

>>> src/nbm_back.sv
// ----------------------------------------------------------------------------
// nbm_back
// Executes the stack operation of one classified character per cycle while the result queue has room.
// Top and next-to-top are registers; deeper levels live in a memory whose
// registered read refills the next-to-top register on a pop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nbm_back #(
  parameter int unsigned MaxDepth = nbm_pkg::NbmMaxDepth,
  localparam int unsigned DepthW  = $clog2(MaxDepth + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire nbm_pkg::cmd_t     cmd_i,
  input  wire logic              cmd_valid_i,
  output logic                   cmd_pop_o,
  output nbm_pkg::res_t          res_o,
  input  wire logic              res_full_i,
  output logic                   res_push_o,
  output logic [DepthW-1:0]      depth_o
);

  localparam int unsigned AddrW = (MaxDepth > 1) ? $clog2(MaxDepth) : 1;

  logic [nbm_pkg::NbmCharW-1:0] stack_mem [MaxDepth];
  logic [nbm_pkg::NbmCharW-1:0] top_q, below_q;
  logic [DepthW-1:0]            depth_q, depth_d, depth_after;
  logic [DepthW-1:0]            wr_idx, rd_idx;
  logic [DepthW+4:0]            depth_wide;
  logic                         fire, at_max, do_push, do_pop;

  // Transfer from the command queue to the result queue
  assign fire       = cmd_valid_i && !res_full_i;
  assign cmd_pop_o  = fire;
  assign res_push_o = fire;
  assign depth_o    = depth_q;

  // Stack decision
  assign at_max  = (depth_q == DepthW'(MaxDepth));
  assign do_push = cmd_i.hit && !at_max;
  assign do_pop  = !cmd_i.hit && (depth_q != '0) && (top_q != '0) && (top_q == cmd_i.ch);

  always_comb begin
    depth_after = depth_q;
    if (do_push) begin
      depth_after = depth_q + DepthW'(1);
    end else if (do_pop) begin
      depth_after = depth_q - DepthW'(1);
    end
  end

  // Result fields
  assign depth_wide = (DepthW + 5)'(depth_after);

  always_comb begin
    res_o.depth = depth_wide[4:0];
    res_o.ovf   = cmd_i.hit && at_max;
    if (cmd_i.hit) begin
      res_o.cls = (!at_max && depth_q == '0) ? nbm_pkg::ClsOpen : nbm_pkg::ClsInside;
    end else if (do_pop) begin
      res_o.cls = (depth_after == '0) ? nbm_pkg::ClsClose : nbm_pkg::ClsInside;
    end else begin
      res_o.cls = (depth_q != '0) ? nbm_pkg::ClsInside : nbm_pkg::ClsOutside;
    end
  end

  // Depth register; last clears it after the result is formed
  assign depth_d = !fire ? depth_q : (cmd_i.last ? '0 : depth_after);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
    end else begin
      depth_q <= depth_d;
    end
  end

  // Top of stack
  always_ff @(posedge clk_i) begin
    if (fire && do_push) begin
      top_q <= cmd_i.closer;
    end else if (fire && do_pop) begin
      top_q <= below_q;
    end
  end

  // Spill to and refill from the memory below the two top levels
  assign wr_idx = depth_q - DepthW'(2);
  assign rd_idx = depth_q - DepthW'(3);

  always_ff @(posedge clk_i) begin
    if (fire && do_push) begin
      if (depth_q > DepthW'(1)) begin
        stack_mem[wr_idx[AddrW-1:0]] <= below_q;
      end
      below_q <= top_q;
    end else if (fire && do_pop) begin
      below_q <= stack_mem[rd_idx[AddrW-1:0]];
    end
  end

endmodule

`default_nettype wire

>>> src/nested_bracket_mask_core.sv
// A pushed character is registered in the command queue, turned into a result
// by the back end and registered in the result queue (empty_o low); a full
// result queue stalls the back end. Throughput: one character per cycle while
// the result queue has room, set by the stack update with top and next-to-top held in registers.
// Reset: rst_ni (async, active low) empties both queues, clears the nesting
// depth and zeroes all delimiter registers; the stack memory is not cleared.
// ----------------------------------------------------------------------------
// nested_bracket_mask_core
// Bracket nesting mask: a front classifier and a stack back end joined by a
// short command queue, with a result queue at the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "nested_bracket_mask_core_assert.svh"

module nested_bracket_mask_core #(
  parameter int unsigned MaxDepth   = nbm_pkg::NbmMaxDepth,
  parameter int unsigned QueueDepth = nbm_pkg::NbmQueueDepth
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration
  input  wire logic                           cfg_we_i,
  input  wire logic [nbm_pkg::NbmCfgIdxW-1:0] cfg_idx_i,
  input  wire logic [nbm_pkg::NbmCharW-1:0]   cfg_wdata_i,
  // characters
  input  wire logic                           push_i,
  output logic                                full_o,
  input  wire logic [nbm_pkg::NbmCharW-1:0]   ch_i,
  input  wire logic                           last_i,
  // results
  output logic                                empty_o,
  input  wire logic                           pop_i,
  output logic [1:0]                          mask_class_o,
  output logic [4:0]                          depth_o,
  output logic                                overflow_o
);

  localparam int unsigned DepthW = $clog2(MaxDepth + 1);

  nbm_pkg::cmd_t     front_cmd, back_cmd;
  nbm_pkg::res_t     back_res, out_res;
  logic              cmd_empty, cmd_pop;
  logic              res_full, res_push;
  logic [DepthW-1:0] stack_depth;

  // Classifier
  nbm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ch_i        (ch_i),
    .last_i      (last_i),
    .cmd_o       (front_cmd)
  );

  // Command queue between front and back
  nbm_fifo #(
    .Width ($bits(nbm_pkg::cmd_t)),
    .Depth (QueueDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .wdata_i (front_cmd),
    .full_o  (full_o),
    .pop_i   (cmd_pop),
    .rdata_o (back_cmd),
    .empty_o (cmd_empty)
  );

  // Stack engine
  nbm_back #(
    .MaxDepth (MaxDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (back_cmd),
    .cmd_valid_i (!cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_o       (back_res),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .depth_o     (stack_depth)
  );

  // Result queue
  nbm_fifo #(
    .Width ($bits(nbm_pkg::res_t)),
    .Depth (QueueDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (back_res),
    .full_o  (res_full),
    .pop_i   (pop_i),
    .rdata_o (out_res),
    .empty_o (empty_o)
  );

  assign mask_class_o = out_res.cls;
  assign depth_o      = out_res.depth;
  assign overflow_o   = out_res.ovf;

  // Checks
  `NBM_ASSERT(a_depth_bound, stack_depth <= DepthW'(MaxDepth), "stack depth above maximum")
  `NBM_ASSERT_IMP(a_ovf_inside, !empty_o && overflow_o, mask_class_o == nbm_pkg::ClsInside, "overflow result not inside")
  `NBM_ASSERT_IMP(a_close_zero, !empty_o && mask_class_o == nbm_pkg::ClsClose, depth_o == 5'd0, "outer close with nonzero depth")
  `NBM_ASSERT_IMP(a_last_clear, res_push && back_cmd.last, ##1 stack_depth == '0, "depth not cleared after last")

endmodule

`default_nettype wire
